FILE: hdl/rtp_pkg.sv
// Shared types, constants and the arctangent table of the rectangular to polar converter.
package rtp_pkg;

   localparam int DW          = 35;
   localparam int ZW          = 27;
   localparam int ANGLE_W     = 16;
   localparam int TABLE_LEN   = 24;
   localparam int MUL_SPLIT   = 17;
   localparam int GAIN_W      = 30;
   localparam int PROD_W      = MUL_SPLIT + GAIN_W;
   localparam int ANGLE_SHIFT = 9;

   localparam logic [GAIN_W-1:0]      INV_GAIN       = 30'd652032874;
   localparam logic signed [ZW-1:0]   HALF_TURN_Z    = 27'sd11796480;
   localparam logic signed [ZW-1:0]   Z_ROUND        = 27'sd256;
   localparam logic signed [ZW-1:0]   Z_ANGLE_LIMIT  = 27'sd23040;
   localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd23040;

   typedef struct packed {
      logic origin;
      logic y_zero;
      logic x_neg;
   } rtp_flags_type;

   typedef struct packed {
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
      logic signed [ZW-1:0] z;
      rtp_flags_type        flags;
   } rtp_vec_type;

   // The arctangent of 2^-idx in degrees, scaled by 65536.
   function automatic logic signed [ZW-1:0] atan_step(input int unsigned idx);
      logic signed [ZW-1:0] r;
      case (idx)
         0:  r = 27'sd2949120;
         1:  r = 27'sd1740967;
         2:  r = 27'sd919879;
         3:  r = 27'sd466945;
         4:  r = 27'sd234379;
         5:  r = 27'sd117304;
         6:  r = 27'sd58666;
         7:  r = 27'sd29335;
         8:  r = 27'sd14668;
         9:  r = 27'sd7334;
         10: r = 27'sd3667;
         11: r = 27'sd1833;
         12: r = 27'sd917;
         13: r = 27'sd458;
         14: r = 27'sd229;
         15: r = 27'sd115;
         16: r = 27'sd57;
         17: r = 27'sd29;
         18: r = 27'sd14;
         19: r = 27'sd7;
         20: r = 27'sd4;
         21: r = 27'sd2;
         22: r = 27'sd1;
         default: r = 27'sd0;
      endcase
      return r;
   endfunction

endpackage

FILE: hdl/rtp_req_if.sv
// Request channel carrying one rectangular coordinate pair.
interface rtp_req_if #(parameter int COORD_WIDTH = 16) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] x_coord;
   logic signed [COORD_WIDTH-1:0] y_coord;

   modport source (output valid, output x_coord, output y_coord, input ready);
   modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

FILE: hdl/rtp_rsp_if.sv
// Response channel carrying one magnitude and angle pair.
interface rtp_rsp_if #(parameter int COORD_WIDTH = 16) ();
   logic                   valid;
   logic                   ready;
   logic [COORD_WIDTH+1:0] magnitude;
   logic signed [15:0]     angle_deg;

   modport source (output valid, output magnitude, output angle_deg, input ready);
   modport sink (input valid, input magnitude, input angle_deg, output ready);
endinterface

FILE: hdl/rtp_prep.sv
// Input stage: scales the coordinates, folds the left half plane and seeds the angle.
module rtp_prep #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] x_coord,
   input  logic signed [COORD_WIDTH-1:0] y_coord,
   output logic                          out_valid,
   input  logic                          out_ready,
   output rtp_pkg::rtp_vec_type          out_vec
);
   import rtp_pkg::*;

   localparam int GUARD = 32 - COORD_WIDTH;

   logic                 valid_ff;
   rtp_vec_type          vec_ff;
   rtp_vec_type          vec_in;
   logic signed [DW-1:0] xs;
   logic signed [DW-1:0] ys;

   always_comb begin
      xs = DW'(x_coord) <<< GUARD;
      ys = DW'(y_coord) <<< GUARD;
      vec_in.flags.x_neg  = x_coord[COORD_WIDTH-1];
      vec_in.flags.y_zero = (y_coord == '0);
      vec_in.flags.origin = (x_coord == '0) && (y_coord == '0);
      if (x_coord[COORD_WIDTH-1]) begin
         vec_in.x = -xs;
         vec_in.y = -ys;
         vec_in.z = y_coord[COORD_WIDTH-1] ? -HALF_TURN_Z : HALF_TURN_Z;
      end else begin
         vec_in.x = xs;
         vec_in.y = ys;
         vec_in.z = '0;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         vec_ff <= vec_in;
      end
   end

endmodule

FILE: hdl/rtp_cordic_stage.sv
// One vectoring micro-rotation of the pipelined CORDIC.
module rtp_cordic_stage #(
   parameter int STAGE = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  rtp_pkg::rtp_vec_type in_vec,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rtp_pkg::rtp_vec_type out_vec
);
   import rtp_pkg::*;

   localparam logic signed [ZW-1:0] ATAN = atan_step(STAGE);

   logic                 valid_ff;
   rtp_vec_type          vec_ff;
   rtp_vec_type          vec_in;
   logic signed [DW-1:0] dx;
   logic signed [DW-1:0] dy;

   always_comb begin
      dx = in_vec.y >>> STAGE;
      dy = in_vec.x >>> STAGE;
      vec_in.flags = in_vec.flags;
      if (!in_vec.y[DW-1]) begin
         vec_in.x = in_vec.x + dx;
         vec_in.y = in_vec.y - dy;
         vec_in.z = in_vec.z + ATAN;
      end else begin
         vec_in.x = in_vec.x - dx;
         vec_in.y = in_vec.y + dy;
         vec_in.z = in_vec.z - ATAN;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         vec_ff <= vec_in;
      end
   end

endmodule

FILE: hdl/rtp_post.sv
// Output stages: gain compensation of the magnitude and rounding of the angle.
module rtp_post #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  rtp_pkg::rtp_vec_type   in_vec,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [COORD_WIDTH+1:0] magnitude,
   output logic signed [15:0]     angle_deg
);
   import rtp_pkg::*;

   localparam int MW     = COORD_WIDTH + 2;
   localparam int SHIFT  = 60 - COORD_WIDTH;
   localparam int SUM_W  = 2 * MUL_SPLIT + GAIN_W + 1;
   localparam logic [SUM_W-1:0] ROUND   = SUM_W'(1) << (SHIFT - 1);
   localparam logic [SUM_W-1:0] MAG_MAX = (SUM_W'(1) << MW) - SUM_W'(1);

   logic                        valid1_ff;
   logic [PROD_W-1:0]           hi_prod_ff;
   logic [PROD_W-1:0]           lo_prod_ff;
   logic signed [ANGLE_W-1:0]   ang1_ff;
   logic                        origin1_ff;
   logic                        valid2_ff;
   logic [MW-1:0]               mag2_ff;
   logic signed [ANGLE_W-1:0]   ang2_ff;
   logic                        origin2_ff;

   logic                        ready1;
   logic                        ready2;
   logic [PROD_W-1:0]           hi_prod_in;
   logic [PROD_W-1:0]           lo_prod_in;
   logic signed [ZW-1:0]        z_round;
   logic signed [ZW-1:0]        z_scaled;
   logic signed [ANGLE_W-1:0]   ang1_in;
   logic [SUM_W-1:0]            mag_sum;
   logic [SUM_W-1:0]            mag_full;
   logic [MW-1:0]               mag2_in;

   always_comb begin
      hi_prod_in = {{GAIN_W{1'b0}}, in_vec.x[2*MUL_SPLIT-1:MUL_SPLIT]}
                   * {{MUL_SPLIT{1'b0}}, INV_GAIN};
      lo_prod_in = {{GAIN_W{1'b0}}, in_vec.x[MUL_SPLIT-1:0]}
                   * {{MUL_SPLIT{1'b0}}, INV_GAIN};
      z_round  = in_vec.z + Z_ROUND;
      z_scaled = z_round >>> ANGLE_SHIFT;
      if (in_vec.flags.origin) begin
         ang1_in = '0;
      end else if (in_vec.flags.y_zero) begin
         ang1_in = in_vec.flags.x_neg ? ANGLE_LIMIT : '0;
      end else if (z_scaled > Z_ANGLE_LIMIT) begin
         ang1_in = ANGLE_LIMIT;
      end else if (z_scaled < -Z_ANGLE_LIMIT) begin
         ang1_in = -ANGLE_LIMIT;
      end else begin
         ang1_in = z_scaled[ANGLE_W-1:0];
      end
   end

   always_comb begin
      mag_sum  = {1'b0, hi_prod_ff, {MUL_SPLIT{1'b0}}} + SUM_W'(lo_prod_ff) + ROUND;
      mag_full = mag_sum >> SHIFT;
      mag2_in  = (mag_full > MAG_MAX) ? MAG_MAX[MW-1:0] : mag_full[MW-1:0];
   end

   assign ready2    = !valid2_ff || out_ready;
   assign ready1    = !valid1_ff || ready2;
   assign in_ready  = ready1;
   assign out_valid = valid2_ff;
   assign magnitude = mag2_ff;
   assign angle_deg = ang2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         if (ready1) begin
            valid1_ff <= in_valid;
         end
         if (ready2) begin
            valid2_ff <= valid1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && in_valid) begin
         hi_prod_ff <= hi_prod_in;
         lo_prod_ff <= lo_prod_in;
         ang1_ff    <= ang1_in;
         origin1_ff <= in_vec.flags.origin;
      end
      if (ready2 && valid1_ff) begin
         mag2_ff    <= mag2_in;
         ang2_ff    <= ang1_ff;
         origin2_ff <= origin1_ff;
      end
   end

`ifndef SYNTH
   a_x_nonneg: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> !in_vec.x[DW-1])
      else $error("CORDIC x went negative at the output stage.");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      valid2_ff |-> (ang2_ff <= ANGLE_LIMIT) && (ang2_ff >= -ANGLE_LIMIT))
      else $error("Angle left the half-turn range.");

   a_origin_zero: assert property (@(posedge clock) disable iff (reset)
      valid2_ff && origin2_ff |-> (mag2_ff == '0) && (ang2_ff == '0))
      else $error("Origin request gave a nonzero result.");

   a_hold_stage1: assert property (@(posedge clock) disable iff (reset)
      valid1_ff && !ready2 |=> valid1_ff && $stable(ang1_ff) && $stable(hi_prod_ff))
      else $error("Multiply stage lost data while stalled.");
`endif

endmodule

FILE: hdl/rect_to_polar_converter.sv
// Top level of the pipelined CORDIC rectangular to polar converter.
//
// A request on req_chan carries a signed pair (x_coord, y_coord); each request yields exactly
// one response on rsp_chan with the magnitude (unsigned, two fraction bits, gain compensated)
// and the angle atan2(y, x) in units of 1/128 degree, from -180 to +180 degrees.
// The origin gives magnitude zero and angle zero; the negative x axis gives +180 degrees.
// Both channels use valid/ready; a transfer happens on a clock edge where both are high.
// The pipeline has one input stage, one stage per micro-rotation (at most 24), one multiply
// stage and one rounding stage; every stage holds its own valid bit. Throughput is one request
// per cycle while rsp_chan.ready stays high.
// When the receiver stalls, the last stage holds its response and the stages behind it keep
// filling until the pipeline is full, then req_chan.ready falls. Nothing is lost or repeated.
// A synchronous, active-high reset empties the pipeline; the block holds no other state.
module rect_to_polar_converter #(
   parameter int ITERATIONS  = 16,
   parameter int COORD_WIDTH = 16
) (
   input logic        clock,
   input logic        reset,
   rtp_req_if.sink    req_chan,
   rtp_rsp_if.source  rsp_chan
);
   import rtp_pkg::*;

   localparam int STAGES = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;

   rtp_vec_type vec   [STAGES+1];
   logic        valid [STAGES+1];
   logic        ready [STAGES+1];

   rtp_prep #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .x_coord   (req_chan.x_coord),
      .y_coord   (req_chan.y_coord),
      .out_valid (valid[0]),
      .out_ready (ready[0]),
      .out_vec   (vec[0])
   );

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      rtp_cordic_stage #(
         .STAGE (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid[i]),
         .in_ready  (ready[i]),
         .in_vec    (vec[i]),
         .out_valid (valid[i+1]),
         .out_ready (ready[i+1]),
         .out_vec   (vec[i+1])
      );
   end

   rtp_post #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid[STAGES]),
      .in_ready  (ready[STAGES]),
      .in_vec    (vec[STAGES]),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .magnitude (rsp_chan.magnitude),
      .angle_deg (rsp_chan.angle_deg)
   );

endmodule
